>>> src/fsq_pkg.sv
// Shared types, constants and binary32 helper functions for the sqrt / rsqrt core.
`timescale 1ns / 1ps
package fsq_pkg;

	localparam logic [31:0] SEED_BIAS = 32'h3F80_0000;
	localparam logic [31:0] ABS_MASK  = 32'h7FFF_FFFF;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] FP_TWO    = 32'h4000_0000;
	localparam logic [31:0] FP_FOUR   = 32'h4080_0000;

	// Unit latencies in cycles
	localparam int MUL_LAT = 2;
	localparam int ADD_LAT = 2;
	localparam int DIV_STEPS = 27;
	localparam int DIV_LAT = DIV_STEPS + 2;

	typedef enum logic {
		REQ_SQRT  = 1'b0,
		REQ_RSQRT = 1'b1
	} fsq_req_t;

	// Unpacked operand: value = man / 2^23 * 2^exp
	typedef struct packed {
		logic               sgn;
		logic               is_nan;
		logic               is_inf;
		logic               is_zero;
		logic signed [9:0]  exp;
		logic [23:0]        man;
	} fsq_op_t;

	function automatic fsq_op_t fsq_unpack(input logic [31:0] b);
		fsq_op_t o;
		o.sgn     = b[31];
		o.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		o.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		o.is_zero = (b[30:0] == 31'd0);
		if (b[30:23] == 8'd0) begin
			o.exp = -10'sd126;
			o.man = {1'b0, b[22:0]};
		end else begin
			o.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
			o.man = {1'b1, b[22:0]};
		end
		return o;
	endfunction

	// Leading zero count of a 48-bit word (48 when zero)
	function automatic logic [5:0] fsq_lzc(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

	// Round to nearest even and pack. m[26] is the leading one, value = m / 2^26 * 2^e.
	// m[2] is guard, m[1:0] round and sticky. Handles overflow and gradual underflow.
	function automatic logic [31:0] fsq_round(input logic sgn, input logic signed [11:0] e,
			input logic [26:0] m);
		logic signed [12:0] be;
		logic [12:0]        sh;
		logic [26:0]        mm;
		logic [26:0]        mask;
		logic [7:0]         ef;
		logic               inc;
		logic [30:0]        mag;
		be = 13'(e) + 13'sd127;
		sh = 13'(13'sd1 - be);
		mask = 27'd0;
		if (be >= 13'sd255) begin
			return {sgn, INF_BITS[30:0]};
		end
		if (be <= 13'sd0) begin
			if (sh >= 13'd27) begin
				mm = {26'd0, |m};
			end else begin
				mask = (27'd1 << sh[4:0]) - 27'd1;
				mm = (m >> sh[4:0]) | {26'd0, |(m & mask)};
			end
			ef = 8'd0;
		end else begin
			mm = m;
			ef = be[7:0];
		end
		inc = mm[2] & (mm[1] | mm[0] | mm[3]);
		// carry out of the fraction bumps the exponent, up to infinity
		mag = {ef, mm[25:3]} + 31'(inc);
		return {sgn, mag};
	endfunction

endpackage

>>> src/fsq_dly.sv
// Stallable shift register that keeps side data aligned with the float units.
`timescale 1ns / 1ps
module fsq_dly #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];
endmodule

>>> src/fsq_fmul.sv
// Two-stage binary32 multiplier: significand product, then normalize and round.
`timescale 1ns / 1ps
module fsq_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import fsq_pkg::*;

	fsq_op_t ua, ub;
	logic               sgn_s1, nan_s1, inf_s1, zero_s1;
	logic signed [11:0] e_s1;
	logic [47:0]        prod_s1;
	logic [5:0]         lz;
	logic [47:0]        nrm;
	logic signed [11:0] e2;
	logic [31:0]        res;
	logic [31:0]        y_s2;

	always_comb begin
		ua = fsq_unpack(a);
		ub = fsq_unpack(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= ua.sgn ^ ub.sgn;
			nan_s1  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero)
				| (ua.is_zero & ub.is_inf);
			inf_s1  <= ua.is_inf | ub.is_inf;
			zero_s1 <= ua.is_zero | ub.is_zero;
			e_s1    <= 12'(ua.exp) + 12'(ub.exp);
			prod_s1 <= ua.man * ub.man;
		end
	end

	always_comb begin
		lz  = fsq_lzc(prod_s1);
		nrm = prod_s1 << lz;
		e2  = e_s1 + 12'sd1 - $signed({6'd0, lz});
		if (nan_s1) begin
			res = QNAN_BITS;
		end else if (inf_s1) begin
			res = {sgn_s1, INF_BITS[30:0]};
		end else if (zero_s1) begin
			res = {sgn_s1, 31'd0};
		end else begin
			res = fsq_round(sgn_s1, e2, {nrm[47:22], nrm[21] | (|nrm[20:0])});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= res;
		end
	end

	assign y = y_s2;
endmodule

>>> src/fsq_fadd.sv
// Two-stage binary32 adder: align and add, then normalize and round.
`timescale 1ns / 1ps
module fsq_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import fsq_pkg::*;

	fsq_op_t ua, ub, big, sml;
	logic [9:0]         d;
	logic [26:0]        mb, ms, msh, mask;
	logic [27:0]        sum;
	logic               sgn_s1, nan_s1, inf_s1, isgn_s1, zsgn_s1;
	logic signed [11:0] e_s1;
	logic [27:0]        sum_s1;
	logic [5:0]         lz;
	logic [27:0]        shl;
	logic [26:0]        m;
	logic signed [11:0] e2;
	logic [31:0]        res;
	logic [31:0]        y_s2;

	always_comb begin
		ua = fsq_unpack(a);
		ub = fsq_unpack(b);
		if (b[30:0] > a[30:0]) begin
			big = ub;
			sml = ua;
		end else begin
			big = ua;
			sml = ub;
		end
		d    = 10'(big.exp - sml.exp);
		mb   = {big.man, 3'b000};
		ms   = {sml.man, 3'b000};
		mask = 27'd0;
		if (d >= 10'd27) begin
			msh = {26'd0, |ms};
		end else begin
			mask = (27'd1 << d[4:0]) - 27'd1;
			msh  = (ms >> d[4:0]) | {26'd0, |(ms & mask)};
		end
		if (big.sgn == sml.sgn) begin
			sum = {1'b0, mb} + {1'b0, msh};
		end else begin
			sum = {1'b0, mb} - {1'b0, msh};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= big.sgn;
			nan_s1  <= ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_inf & (ua.sgn != ub.sgn));
			inf_s1  <= ua.is_inf | ub.is_inf;
			isgn_s1 <= ua.is_inf ? ua.sgn : ub.sgn;
			zsgn_s1 <= ua.sgn & ub.sgn;
			e_s1    <= 12'(big.exp);
			sum_s1  <= sum;
		end
	end

	always_comb begin
		lz  = fsq_lzc({sum_s1, 20'd0});
		shl = sum_s1 << (lz - 6'd1);
		if (sum_s1[27]) begin
			m  = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			e2 = e_s1 + 12'sd1;
		end else begin
			m  = shl[26:0];
			e2 = e_s1 - $signed({6'd0, lz}) + 12'sd1;
		end
		if (nan_s1) begin
			res = QNAN_BITS;
		end else if (inf_s1) begin
			res = {isgn_s1, INF_BITS[30:0]};
		end else if (sum_s1 == 28'd0) begin
			// exact zero: negative only when both addends are negative
			res = {zsgn_s1, 31'd0};
		end else begin
			res = fsq_round(sgn_s1, e2, m);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= res;
		end
	end

	assign y = y_s2;
endmodule

>>> src/fsq_fdiv.sv
// Pipelined binary32 divider: one restoring quotient bit per stage, then round.
`timescale 1ns / 1ps
module fsq_fdiv (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import fsq_pkg::*;

	typedef struct packed {
		logic [24:0]        rem;
		logic [23:0]        den;
		logic [26:0]        quo;
		logic signed [11:0] e;
		logic               sgn;
		logic               nan;
		logic               inf;
		logic               zero;
	} step_t;

	function automatic step_t div_step(input step_t s);
		step_t o;
		logic [24:0] diff;
		o = s;
		diff = s.rem - {1'b0, s.den};
		if (s.rem >= {1'b0, s.den}) begin
			o.quo = {s.quo[25:0], 1'b1};
			o.rem = {diff[23:0], 1'b0};
		end else begin
			o.quo = {s.quo[25:0], 1'b0};
			o.rem = {s.rem[23:0], 1'b0};
		end
		return o;
	endfunction

	fsq_op_t ua, ub;
	logic [5:0]  lza, lzb;
	logic [47:0] na, nb;
	step_t       pre;
	step_t       st_s [DIV_STEPS+1];
	step_t       fin;
	logic        stk;
	logic [26:0] m;
	logic signed [11:0] e2;
	logic [31:0] res;
	logic [31:0] y_s2;

	always_comb begin
		ua  = fsq_unpack(a);
		ub  = fsq_unpack(b);
		lza = fsq_lzc({ua.man, 24'd0});
		lzb = fsq_lzc({ub.man, 24'd0});
		na  = {ua.man, 24'd0} << lza;
		nb  = {ub.man, 24'd0} << lzb;
		pre.rem  = {1'b0, na[47:24]};
		pre.den  = nb[47:24];
		pre.quo  = 27'd0;
		pre.e    = (12'(ua.exp) - $signed({6'd0, lza})) - (12'(ub.exp) - $signed({6'd0, lzb}));
		pre.sgn  = ua.sgn ^ ub.sgn;
		pre.nan  = ua.is_nan | ub.is_nan | (ua.is_zero & ub.is_zero) | (ua.is_inf & ub.is_inf);
		pre.inf  = ua.is_inf | ub.is_zero;
		pre.zero = ua.is_zero | ub.is_inf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= pre;
			for (int k = 0; k < DIV_STEPS; k++) begin
				st_s[k+1] <= div_step(st_s[k]);
			end
		end
	end

	always_comb begin
		fin = st_s[DIV_STEPS];
		stk = (fin.rem != 25'd0);
		if (fin.quo[26]) begin
			m  = {fin.quo[26:1], fin.quo[0] | stk};
			e2 = fin.e;
		end else begin
			m  = {fin.quo[25:0], stk};
			e2 = fin.e - 12'sd1;
		end
		if (fin.nan) begin
			res = QNAN_BITS;
		end else if (fin.inf) begin
			res = {fin.sgn, INF_BITS[30:0]};
		end else if (fin.zero) begin
			res = {fin.sgn, 31'd0};
		end else begin
			res = fsq_round(fin.sgn, e2, m);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= res;
		end
	end

	assign y = y_s2;
endmodule

>>> src/fast_float_sqrt_inv_sqrt_core.sv
// Top level of the fast approximate binary32 square root / reciprocal square root core.
`timescale 1ns / 1ps
// Accepts one operand per cycle unless the pipeline is frozen and returns one result per
// operand, in order. The path is the input register loaded at the transfer, the seed
// multiplies, the add/subtract pair, three multiplies, the doubling multiply, the final
// subtract and a divider that resolves one quotient bit per stage. The whole pipeline
// advances together and freezes while a result waits on m_axis_tready.
module fast_float_sqrt_inv_sqrt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] operand_bits
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] result_bits
);
	import fsq_pkg::*;

	localparam int FRONT_LAT = 3 * MUL_LAT + 2 * ADD_LAT;
	localparam int TOTAL_LAT = 1 + FRONT_LAT + DIV_LAT;

	logic                 en;
	logic [TOTAL_LAT-1:0] vld_q;
	logic [31:0]          x_s1, y_s1;
	logic [31:0]          seed;
	fsq_req_t             req_s1;
	logic [31:0] p, q, x2, q2, z, d, s, e, n, e2, n4, mm, w;
	logic [31:0] num, den;
	logic        req_d;

	assign en = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		seed = ((s_axis_tdata - SEED_BIAS) >> 1) + SEED_BIAS;
		seed = seed & ABS_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= s_axis_tdata;
			y_s1   <= seed;
			req_s1 <= fsq_req_t'(s_axis_tuser);
		end
	end

	// p = y*y, q = 4y
	fsq_fmul u_mul_p (.clk(clk), .en(en), .a(y_s1), .b(y_s1), .y(p));
	fsq_fmul u_mul_q (.clk(clk), .en(en), .a(y_s1), .b(FP_FOUR), .y(q));
	fsq_dly #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_x (.clk(clk), .en(en), .din(x_s1), .dout(x2));

	// z = p + x, d = p - x
	fsq_fadd u_add_z (.clk(clk), .en(en), .a(p), .b(x2), .y(z));
	fsq_fadd u_add_d (.clk(clk), .en(en), .a(p), .b({~x2[31], x2[30:0]}), .y(d));
	fsq_dly #(.WIDTH(32), .DEPTH(ADD_LAT)) u_dly_q (.clk(clk), .en(en), .din(q), .dout(q2));

	// s = z*z, e = d*d, n = z*q
	fsq_fmul u_mul_s (.clk(clk), .en(en), .a(z), .b(z), .y(s));
	fsq_fmul u_mul_e (.clk(clk), .en(en), .a(d), .b(d), .y(e));
	fsq_fmul u_mul_n (.clk(clk), .en(en), .a(z), .b(q2), .y(n));

	// m = 2s, then w = m - e
	fsq_fmul u_mul_m (.clk(clk), .en(en), .a(FP_TWO), .b(s), .y(mm));
	fsq_dly #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_e (.clk(clk), .en(en), .din(e), .dout(e2));
	fsq_fadd u_add_w (.clk(clk), .en(en), .a(mm), .b({~e2[31], e2[30:0]}), .y(w));
	fsq_dly #(.WIDTH(32), .DEPTH(MUL_LAT + ADD_LAT)) u_dly_n (
		.clk(clk), .en(en), .din(n), .dout(n4)
	);

	fsq_dly #(.WIDTH(1), .DEPTH(FRONT_LAT)) u_dly_req (
		.clk(clk), .en(en), .din(req_s1), .dout(req_d)
	);

	always_comb begin
		if (fsq_req_t'(req_d) == REQ_RSQRT) begin
			num = n4;
			den = w;
		end else begin
			num = w;
			den = n4;
		end
	end

	fsq_fdiv u_div (.clk(clk), .en(en), .a(num), .b(den), .y(m_axis_tdata));

	assign m_axis_tvalid = vld_q[TOTAL_LAT-1];
endmodule

>>> tb/sv/fast_float_sqrt_inv_sqrt_core_tb.sv
// Self-checking testbench for the fast approximate binary32 sqrt / rsqrt core.
`timescale 1ns / 1ps
module fast_float_sqrt_inv_sqrt_core_tb;
	import fsq_pkg::*;

	localparam int N_RANDOM     = 1630;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 60;

	// Bit-exact binary32 predictor and the queue of results still owed by the core.
	class sqrt_scoreboard;
		logic [31:0] owed_results[$];

		function automatic logic is_nan(logic [31:0] b);
			return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		endfunction

		function automatic logic is_inf(logic [31:0] b);
			return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		endfunction

		function automatic logic is_zero(logic [31:0] b);
			return b[30:0] == 31'd0;
		endfunction

		// value = m * 2^e
		function automatic void split(input logic [31:0] b, output int e, output logic [23:0] m);
			if (b[30:23] == 8'd0) begin
				m = {1'b0, b[22:0]};
				e = -149;
			end else begin
				m = {1'b1, b[22:0]};
				e = int'(b[30:23]) - 150;
			end
		endfunction

		// round to nearest even, value = m * 2^e; a set lsb below the guard acts as sticky
		function automatic logic [31:0] pack(logic s, int e, logic [65:0] m);
			int k;
			int sh;
			int be;
			logic [65:0] keep;
			logic g;
			logic st;
			if (m == 66'd0) return {s, 31'd0};
			k = 0;
			for (int i = 0; i < 66; i++) if (m[i]) k = i;
			sh = k - 23;
			if (sh < -149 - e) sh = -149 - e;
			if (sh >= 67) begin
				keep = 66'd0;
				g = 1'b0;
				st = 1'b1;
			end else if (sh > 0) begin
				keep = m >> sh;
				g = m[sh-1];
				st = (m & ((66'd1 << (sh - 1)) - 66'd1)) != 66'd0;
			end else begin
				keep = m << (-sh);
				g = 1'b0;
				st = 1'b0;
			end
			if (g && (st || keep[0])) keep = keep + 66'd1;
			if (keep[24]) begin
				keep = keep >> 1;
				sh++;
			end
			if (keep[23]) begin
				be = e + sh + 23 + 127;
				if (be >= 255) return {s, 8'hFF, 23'd0};
				return {s, be[7:0], keep[22:0]};
			end
			return {s, 8'd0, keep[22:0]};
		endfunction

		function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
			int ea;
			int eb;
			logic [23:0] ma;
			logic [23:0] mb;
			logic s;
			s = a[31] ^ b[31];
			if (is_nan(a) || is_nan(b)) return QNAN_BITS;
			if (is_inf(a) || is_inf(b)) begin
				if (is_zero(a) || is_zero(b)) return QNAN_BITS;
				return {s, 8'hFF, 23'd0};
			end
			split(a, ea, ma);
			split(b, eb, mb);
			return pack(s, ea + eb, 66'(ma) * 66'(mb));
		endfunction

		function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
			int ea;
			int eb;
			int d;
			logic [23:0] ma;
			logic [23:0] mb;
			logic [65:0] wa;
			logic [65:0] wb;
			logic [65:0] sum;
			logic [31:0] t;
			if (is_nan(a) || is_nan(b)) return QNAN_BITS;
			if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN_BITS;
			if (is_inf(a)) return a;
			if (is_inf(b)) return b;
			if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
			if (is_zero(a)) return b;
			if (is_zero(b)) return a;
			split(a, ea, ma);
			split(b, eb, mb);
			if (ea < eb) begin
				t = a; a = b; b = t;
				split(a, ea, ma);
				split(b, eb, mb);
			end
			d = ea - eb;
			wa = 66'(ma) << 40;
			wb = 66'(mb) << 40;
			if (d >= 66) begin
				wb = 66'd1;
			end else if (d > 0) begin
				wb = (wb >> d) | 66'(((wb & ((66'd1 << d) - 66'd1)) != 66'd0));
			end
			if (a[31] == b[31]) return pack(a[31], ea - 40, wa + wb);
			if (wa == wb) return 32'd0;
			if (wa > wb) return pack(a[31], ea - 40, wa - wb);
			sum = wb - wa;
			return pack(b[31], ea - 40, sum);
		endfunction

		function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
			int ea;
			int eb;
			logic [23:0] ma;
			logic [23:0] mb;
			logic [65:0] num;
			logic [65:0] quo;
			logic s;
			s = a[31] ^ b[31];
			if (is_nan(a) || is_nan(b)) return QNAN_BITS;
			if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) return QNAN_BITS;
			if (is_inf(a) || is_zero(b)) return {s, 8'hFF, 23'd0};
			if (is_inf(b) || is_zero(a)) return {s, 31'd0};
			split(a, ea, ma);
			split(b, eb, mb);
			while (!ma[23]) begin
				ma = ma << 1;
				ea--;
			end
			while (!mb[23]) begin
				mb = mb << 1;
				eb--;
			end
			num = 66'(ma) << 40;
			quo = num / 66'(mb);
			quo = (quo << 1) | 66'((num % 66'(mb)) != 66'd0);
			return pack(s, ea - eb - 41, quo);
		endfunction

		function automatic logic [31:0] approx_root(fsq_req_t req, logic [31:0] x);
			logic [31:0] y, p, z, d, q, s, e, n, m, w, r;
			y = ((((x - SEED_BIAS) >> 1) + SEED_BIAS) & ABS_MASK);
			p = fmul(y, y);
			z = fadd(p, x);
			d = fadd(p, x ^ 32'h8000_0000);
			q = fmul(y, FP_FOUR);
			s = fmul(z, z);
			e = fmul(d, d);
			n = fmul(z, q);
			m = fmul(FP_TWO, s);
			w = fadd(m, e ^ 32'h8000_0000);
			r = (req == REQ_SQRT) ? fdiv(w, n) : fdiv(n, w);
			return is_nan(r) ? QNAN_BITS : r;
		endfunction

		function void note_operand(fsq_req_t req, logic [31:0] x);
			owed_results.push_back(approx_root(req, x));
		endfunction

		// 0: match, 1: nothing owed, 2: wrong value
		function int check_result(logic [31:0] got, output logic [31:0] want);
			want = 32'd0;
			if (owed_results.size() == 0) return 1;
			want = owed_results.pop_front();
			return (got === want) ? 0 : 2;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	sqrt_scoreboard sb = new();
	int errors = 0;
	int idle_cycles = 0;
	int sent_count = 0;
	logic hold_request = 1'b0;

	fast_float_sqrt_inv_sqrt_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got %08h want %08h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(fsq_req_t req, logic [31:0] x);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = x;
		s_axis_tuser = req;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent_count++;
	endtask

	function automatic logic [31:0] random_operand();
		int r;
		logic [31:0] b;
		r = $urandom_range(0, 9);
		b = $urandom();
		case (r)
			0, 1: begin
			end
			2: begin
				b[30:23] = 8'd0;
			end
			3: begin
				b[30:23] = 8'($urandom_range(200, 255));
			end
			4: begin
				b[30:23] = 8'($urandom_range(1, 40));
			end
			default: begin
				b[31] = 1'b0;
				b[30:23] = 8'($urandom_range(90, 170));
			end
		endcase
		return b;
	endfunction

	// sender
	initial begin
		logic [31:0] corner[11];
		corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
			32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hC080_0000,
			32'hFFFF_FFFF};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 32'd0;
		s_axis_tuser = REQ_SQRT;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (corner[i]) begin
			send_item(REQ_SQRT, corner[i]);
			send_item(REQ_RSQRT, corner[i]);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 500) hold_request = 1'b1;
			send_item(fsq_req_t'($urandom_range(0, 1)), random_operand());
		end
		s_axis_tvalid = 1'b0;
		wait (sb.owed_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// receiver, with one long hold-off to back the pipeline up
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (sent_count > 1000 && sent_count < 1200) begin
				m_axis_tready = 1'b1;
			end else if (gap_length() > 0) begin
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		logic [31:0] want;
		int verdict;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				verdict = sb.check_result(m_axis_tdata, want);
				if (verdict == 1) report("unexpected result", m_axis_tdata, want);
				else if (verdict == 2) report("result_bits", m_axis_tdata, want);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_operand(fsq_req_t'(s_axis_tuser), s_axis_tdata);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

>>> sim.f
src/fsq_pkg.sv
src/fsq_dly.sv
src/fsq_fmul.sv
src/fsq_fadd.sv
src/fsq_fdiv.sv
src/fast_float_sqrt_inv_sqrt_core.sv
tb/sv/fast_float_sqrt_inv_sqrt_core_tb.sv
